[src/tpq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tpq_pkg;

  localparam int IdW  = 16;
  localparam int TagW = 16;
  localparam int PosW = 4;

  // request codes
  typedef enum logic [2:0] {
    MODE_ADD_NORM = 3'd0,
    MODE_ADD_PRI  = 3'd1,
    MODE_CANCEL   = 3'd2,
    MODE_DEQ      = 3'd3,
    MODE_PEEK     = 3'd4,
    MODE_LOCATE   = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [TagW-1:0] tag;
    logic            pri;
  } entry_t;

  typedef struct packed {
    status_e         status;
    logic [IdW-1:0]  id;
    logic [TagW-1:0] tag;
    logic            pri;
    logic [PosW-1:0] pos;
  } res_t;

endpackage

`default_nettype wire

[src/two_class_priority_queue.sv]
// two-class priority queue: a ring of DEPTH entries (id, tag, class) kept in
// order with all priority entries first, each class first-in first-out
// input channel: in_valid_i / in_stall_o carry one request item (mode_i,
// target_id_i, tag_i); one request is worked on at a time and in_stall_o
// stays high from acceptance until its result has moved to the output register
// output channel: out_valid_o / out_stall_i carry one result item per request
// add normal, add priority with no normal entries waiting, a full or empty
// result, an unused code, and cancel or locate on an empty queue go straight
// to the done state; add priority with normal entries waiting first shifts
// them back one place, last one first; peek, dequeue, locate and cancel scan
// the entries from the head until a match or the end, and cancel then moves
// the entries after the match forward one place to close the gap
// the next request can be taken in the cycle after the result enters the
// output register; the scan and the shift both walk the entries one per
// cycle through the single store read port
// a stalled result holds in the output register; the next request may be
// accepted behind it but its result waits until the register is free
// reset clears counts and head, sets the next id to one; store not cleared
`timescale 1ns / 1ps
`default_nettype none

module two_class_priority_queue #(
  parameter int DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request items
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  mode_i,
  input  wire logic [15:0] target_id_i,
  input  wire logic [15:0] tag_i,
  // result items
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [15:0]      entry_id_o,
  output logic [15:0]      entry_tag_o,
  output logic             entry_priority_o,
  output logic [3:0]       position_o,
  output logic [4:0]       occupancy_o,
  output logic [4:0]       priority_occupancy_o
);

  localparam int CW = $clog2(DEPTH + 1);

  logic          take;       // output register free this cycle
  logic          res_valid;
  tpq_pkg::res_t res;
  logic [CW-1:0] cnt, pcnt;
  logic          out_valid_q;

  assign take = !(out_valid_q && out_stall_i);

  // sequencer, address unit and entry store
  tpq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .target_id_i (target_id_i),
    .tag_i       (tag_i),
    .take_i      (take),
    .res_valid_o (res_valid),
    .res_o       (res),
    .cnt_o       (cnt),
    .pcnt_o      (pcnt)
  );

  // output register, counts are final once the sequencer sits in its done state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && res_valid) begin
      status_o             <= res.status;
      entry_id_o           <= res.id;
      entry_tag_o          <= res.tag;
      entry_priority_o     <= res.pri;
      position_o           <= res.pos;
      occupancy_o          <= 5'(cnt);
      priority_occupancy_o <= 5'(pcnt);
    end
  end

  assign out_valid_o = out_valid_q;

  // priority entries are a subset of all entries
  assert property (@(posedge clk_i) disable iff (!rst_ni) pcnt <= cnt)
    else $error("priority count exceeds occupancy");

  // occupancy never exceeds the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt <= CW'(DEPTH))
    else $error("occupancy exceeds depth");

  // one request at a time: an accepted item closes the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while another is in flight");

  // an empty report always comes with no entries held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == tpq_pkg::ST_EMPTY) |-> (occupancy_o == 5'd0))
    else $error("empty status with entries held");

endmodule

`default_nettype wire

[src/tpq_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module tpq_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[src/tpq_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module tpq_ctrl #(
  parameter int DEPTH = 16,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [2:0]           mode_i,
  input  wire logic [15:0]          target_id_i,
  input  wire logic [15:0]          tag_i,
  input  wire logic                 take_i,
  output logic                      res_valid_o,
  output tpq_pkg::res_t             res_o,
  output logic      [CW-1:0]        cnt_o,
  output logic      [CW-1:0]        pcnt_o
);

  localparam int IW = $clog2(DEPTH);
  localparam int EW = $bits(tpq_pkg::entry_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE,
    S_DONE
  } state_e;

  state_e                        state_q, state_d;
  tpq_pkg::mode_e                mode_q, mode_d, mode_in;
  logic [tpq_pkg::IdW-1:0]       target_q, target_d;
  logic [tpq_pkg::TagW-1:0]      tag_q, tag_d;
  logic [IW-1:0]                 head_q, head_d, head_inc;
  logic [CW-1:0]                 cnt_q, cnt_d, pcnt_q, pcnt_d;
  logic [tpq_pkg::IdW-1:0]       nid_q, nid_d, nid_inc;
  logic [CW-1:0]                 rd_q, rd_d, cmp_q, cmp_d, n_q, n_d;
  logic                          cv_q, cv_d;
  tpq_pkg::res_t                 res_q, res_d;
  logic                          hit;

  logic                          rd_en, wr_en;
  logic [IW-1:0]                 rd_addr, wr_addr;
  tpq_pkg::entry_t               wr_data, rd_data;
  logic [EW-1:0]                 rd_raw;

  // offset from head to slot index, sum stays below twice the depth
  function automatic logic [IW-1:0] ring_addr(logic [IW-1:0] head, logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(head) + (CW+1)'(off);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  assign mode_in  = tpq_pkg::mode_e'(mode_i);
  assign head_inc = (head_q == IW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign nid_inc  = (nid_q == '1) ? tpq_pkg::IdW'(1) : nid_q + 1'b1;
  assign rd_data  = tpq_pkg::entry_t'(rd_raw);

  assign hit = cv_q && (mode_q == tpq_pkg::MODE_DEQ || mode_q == tpq_pkg::MODE_PEEK ||
                        rd_data.id == target_q);

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    target_d = target_q;
    tag_d   = tag_q;
    head_d  = head_q;
    cnt_d   = cnt_q;
    pcnt_d  = pcnt_q;
    nid_d   = nid_q;
    rd_d    = rd_q;
    cmp_d   = cmp_q;
    cv_d    = cv_q;
    n_d     = n_q;
    res_d   = res_q;
    rd_en   = 1'b0;
    rd_addr = ring_addr(head_q, rd_q);
    wr_en   = 1'b0;
    wr_addr = ring_addr(head_q, cmp_q);
    wr_data = rd_data;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d   = mode_in;
          target_d = target_id_i;
          tag_d    = tag_i;
          res_d    = '0;
          rd_d     = '0;
          cv_d     = 1'b0;
          state_d  = S_DONE;
          case (mode_in)
            tpq_pkg::MODE_ADD_NORM, tpq_pkg::MODE_ADD_PRI: begin
              if (cnt_q == CW'(DEPTH)) begin
                res_d.status = tpq_pkg::ST_FULL;
              end else if (mode_in == tpq_pkg::MODE_ADD_NORM || pcnt_q == cnt_q) begin
                // lands at the tail, nothing to shift
                wr_en       = 1'b1;
                wr_addr     = ring_addr(head_q, cnt_q);
                wr_data.id  = nid_q;
                wr_data.tag = tag_i;
                wr_data.pri = (mode_in == tpq_pkg::MODE_ADD_PRI);
                res_d.id    = nid_q;
                res_d.tag   = tag_i;
                res_d.pri   = (mode_in == tpq_pkg::MODE_ADD_PRI);
                cnt_d       = cnt_q + 1'b1;
                if (mode_in == tpq_pkg::MODE_ADD_PRI) begin
                  pcnt_d = pcnt_q + 1'b1;
                end
                nid_d       = nid_inc;
              end else begin
                // shift normal entries back, last one first
                rd_d    = cnt_q - 1'b1;
                n_d     = cnt_q - pcnt_q;
                state_d = S_MOVE;
              end
            end
            tpq_pkg::MODE_CANCEL, tpq_pkg::MODE_LOCATE: begin
              if (cnt_q == '0) begin
                res_d.status = tpq_pkg::ST_NOT_FOUND;
              end else begin
                state_d = S_SCAN;
              end
            end
            tpq_pkg::MODE_DEQ, tpq_pkg::MODE_PEEK: begin
              if (cnt_q == '0) begin
                res_d.status = tpq_pkg::ST_EMPTY;
              end else begin
                state_d = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        if (hit) begin
          res_d.status = tpq_pkg::ST_OK;
          res_d.id     = rd_data.id;
          res_d.tag    = rd_data.tag;
          res_d.pri    = rd_data.pri;
          res_d.pos    = (mode_q == tpq_pkg::MODE_LOCATE) ? tpq_pkg::PosW'(cmp_q) : '0;
          cv_d         = 1'b0;
          state_d      = S_DONE;
          case (mode_q)
            tpq_pkg::MODE_DEQ: begin
              head_d = head_inc;
              cnt_d  = cnt_q - 1'b1;
              if (rd_data.pri) begin
                pcnt_d = pcnt_q - 1'b1;
              end
            end
            tpq_pkg::MODE_CANCEL: begin
              // close the gap, first entry after the hit first
              rd_d    = cmp_q + 1'b1;
              n_d     = cnt_q - cmp_q - 1'b1;
              state_d = S_MOVE;
            end
            default: begin
            end
          endcase
        end else if (rd_q != cnt_q) begin
          rd_en = 1'b1;
          cmp_d = rd_q;
          rd_d  = rd_q + 1'b1;
          cv_d  = 1'b1;
        end else begin
          res_d.status = tpq_pkg::ST_NOT_FOUND;
          cv_d         = 1'b0;
          state_d      = S_DONE;
        end
      end

      S_MOVE: begin
        if (cv_q) begin
          wr_en = 1'b1;
        end
        if (n_q != '0) begin
          rd_en = 1'b1;
          n_d   = n_q - 1'b1;
          cv_d  = 1'b1;
          if (mode_q == tpq_pkg::MODE_ADD_PRI) begin
            cmp_d = rd_q + 1'b1;
            rd_d  = rd_q - 1'b1;
          end else begin
            cmp_d = rd_q - 1'b1;
            rd_d  = rd_q + 1'b1;
          end
        end else begin
          cv_d = 1'b0;
          if (!cv_q) begin
            state_d = S_DONE;
            if (mode_q == tpq_pkg::MODE_ADD_PRI) begin
              wr_en        = 1'b1;
              wr_addr      = ring_addr(head_q, pcnt_q);
              wr_data.id   = nid_q;
              wr_data.tag  = tag_q;
              wr_data.pri  = 1'b1;
              res_d.status = tpq_pkg::ST_OK;
              res_d.id     = nid_q;
              res_d.tag    = tag_q;
              res_d.pri    = 1'b1;
              cnt_d        = cnt_q + 1'b1;
              pcnt_d       = pcnt_q + 1'b1;
              nid_d        = nid_inc;
            end else begin
              cnt_d = cnt_q - 1'b1;
              if (res_q.pri) begin
                pcnt_d = pcnt_q - 1'b1;
              end
            end
          end
        end
      end

      S_DONE: begin
        if (take_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mode_q   <= tpq_pkg::MODE_ADD_NORM;
      target_q <= '0;
      tag_q    <= '0;
      head_q   <= '0;
      cnt_q    <= '0;
      pcnt_q   <= '0;
      nid_q    <= tpq_pkg::IdW'(1);
      rd_q     <= '0;
      cmp_q    <= '0;
      cv_q     <= 1'b0;
      n_q      <= '0;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      target_q <= target_d;
      tag_q    <= tag_d;
      head_q   <= head_d;
      cnt_q    <= cnt_d;
      pcnt_q   <= pcnt_d;
      nid_q    <= nid_d;
      rd_q     <= rd_d;
      cmp_q    <= cmp_d;
      cv_q     <= cv_d;
      n_q      <= n_d;
      res_q    <= res_d;
    end
  end

  tpq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (EW'(wr_data)),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_raw)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;
  assign cnt_o       = cnt_q;
  assign pcnt_o      = pcnt_q;

endmodule

`default_nettype wire
